// File: rtl/core/obb_pkg.sv
`default_nettype none
package obb_pkg;

  localparam int CW  = 24;  // center coordinate
  localparam int EW  = 23;  // half extent
  localparam int TW  = 16;  // cos / sin, Q1.14
  localparam int AW  = TW + 1;   // axis component, room for negated -32768
  localparam int DW  = CW + 1;   // center difference
  localparam int PW  = 2 * AW;   // axis * axis product
  localparam int SW  = PW + 1;   // axis dot product
  localparam int MW  = 32;       // |axis dot axis|, at most 2^31
  localparam int NPW = DW + AW;  // difference * axis product
  localparam int NSW = NPW + 1;  // difference dot axis
  localparam int NMW = 41;       // |difference dot axis|, at most 2^40
  localparam int FW  = 14;       // scale of projection to Q28
  localparam int TRW = EW + MW;  // extent * |dot|
  localparam int RBW = TRW + 1;  // radius of one box
  localparam int RW  = RBW + 1;  // sum of both radii

  localparam int NAX = 4;        // axes tested
  localparam int NBX = 2;        // boxes

  typedef logic signed [AW-1:0] axis_t;

  typedef struct packed {
    logic [NAX-1:0][NAX-1:0][MW-1:0] dmag;
    logic [NAX-1:0][NMW-1:0]         pmag;
    logic [NBX-1:0][EW-1:0]          hw;
    logic [NBX-1:0][EW-1:0]          hh;
  } obb_proj_t;

endpackage
`default_nettype wire

// File: rtl/core/obb_overlap_test_2d.sv
`default_nettype none
// 2D oriented box overlap test (separating axis test over the four box axes).
// Six register stages: one word enters per cycle while in_ready is high;
// sustained rate is one box pair per clock while out_ready stays high. Each
// stage has its own valid bit and moves whenever the stage after it is empty
// or moving, so a stalled output holds its word while upstream bubbles still
// fill in. Touching boxes and degenerate (zero) axes report no overlap.
module obb_overlap_test_2d (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [obb_pkg::CW-1:0] a_center_x,
  input  wire logic signed [obb_pkg::CW-1:0] a_center_y,
  input  wire logic [obb_pkg::EW-1:0]        a_half_width,
  input  wire logic [obb_pkg::EW-1:0]        a_half_height,
  input  wire logic signed [obb_pkg::TW-1:0] a_cos,
  input  wire logic signed [obb_pkg::TW-1:0] a_sin,
  input  wire logic signed [obb_pkg::CW-1:0] b_center_x,
  input  wire logic signed [obb_pkg::CW-1:0] b_center_y,
  input  wire logic [obb_pkg::EW-1:0]        b_half_width,
  input  wire logic [obb_pkg::EW-1:0]        b_half_height,
  input  wire logic signed [obb_pkg::TW-1:0] b_cos,
  input  wire logic signed [obb_pkg::TW-1:0] b_sin,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               overlap
);

  logic [6:1] vld;
  logic [7:1] en;
  obb_pkg::obb_proj_t proj;

  assign en[7] = out_ready;
  for (genvar i = 1; i <= 6; i++) begin : g_en
    assign en[i] = ~vld[i] | en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in_valid;
      for (int i = 2; i <= 6; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[6];

  obb_proj u_proj (
    .clk           (clk),
    .en            (en[3:1]),
    .a_center_x    (a_center_x),
    .a_center_y    (a_center_y),
    .a_half_width  (a_half_width),
    .a_half_height (a_half_height),
    .a_cos         (a_cos),
    .a_sin         (a_sin),
    .b_center_x    (b_center_x),
    .b_center_y    (b_center_y),
    .b_half_width  (b_half_width),
    .b_half_height (b_half_height),
    .b_cos         (b_cos),
    .b_sin         (b_sin),
    .proj          (proj)
  );

  obb_rad u_rad (
    .clk       (clk),
    .en        (en[6:4]),
    .proj      (proj),
    .overlap_q (overlap)
  );

endmodule
`default_nettype wire

// File: rtl/core/obb_proj.sv
`default_nettype none
// Stages 1..3: axes and center difference, products, dot magnitudes.
module obb_proj (
  input  wire logic                          clk,
  input  wire logic [2:0]                    en,
  input  wire logic signed [obb_pkg::CW-1:0] a_center_x,
  input  wire logic signed [obb_pkg::CW-1:0] a_center_y,
  input  wire logic [obb_pkg::EW-1:0]        a_half_width,
  input  wire logic [obb_pkg::EW-1:0]        a_half_height,
  input  wire logic signed [obb_pkg::TW-1:0] a_cos,
  input  wire logic signed [obb_pkg::TW-1:0] a_sin,
  input  wire logic signed [obb_pkg::CW-1:0] b_center_x,
  input  wire logic signed [obb_pkg::CW-1:0] b_center_y,
  input  wire logic [obb_pkg::EW-1:0]        b_half_width,
  input  wire logic [obb_pkg::EW-1:0]        b_half_height,
  input  wire logic signed [obb_pkg::TW-1:0] b_cos,
  input  wire logic signed [obb_pkg::TW-1:0] b_sin,
  output obb_pkg::obb_proj_t                 proj
);

  localparam int AW  = obb_pkg::AW;
  localparam int DW  = obb_pkg::DW;
  localparam int NAX = obb_pkg::NAX;

  // stage 1
  obb_pkg::axis_t ax1 [NAX];
  obb_pkg::axis_t ay1 [NAX];
  logic signed [DW-1:0] nx1, ny1;
  logic [obb_pkg::NBX-1:0][obb_pkg::EW-1:0] hw1, hh1, hw2, hh2;

  // stage 2
  logic signed [obb_pkg::PW-1:0]  px2 [NAX][NAX];
  logic signed [obb_pkg::PW-1:0]  py2 [NAX][NAX];
  logic signed [obb_pkg::NPW-1:0] qx2 [NAX];
  logic signed [obb_pkg::NPW-1:0] qy2 [NAX];

  // stage 3 inputs
  logic signed [obb_pkg::SW-1:0]  sd [NAX][NAX];
  logic signed [obb_pkg::NSW-1:0] sn [NAX];
  logic [NAX-1:0][NAX-1:0][obb_pkg::MW-1:0] dmag_next;
  logic [NAX-1:0][obb_pkg::NMW-1:0]         pmag_next;

  // axis order: A(cos,sin), A(-sin,cos), B(cos,sin), B(-sin,cos)
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ax1[0] <= AW'(a_cos);
      ay1[0] <= AW'(a_sin);
      ax1[1] <= -AW'(a_sin);
      ay1[1] <= AW'(a_cos);
      ax1[2] <= AW'(b_cos);
      ay1[2] <= AW'(b_sin);
      ax1[3] <= -AW'(b_sin);
      ay1[3] <= AW'(b_cos);
      nx1    <= DW'(a_center_x) - DW'(b_center_x);
      ny1    <= DW'(a_center_y) - DW'(b_center_y);
      hw1[0] <= a_half_width;
      hh1[0] <= a_half_height;
      hw1[1] <= b_half_width;
      hh1[1] <= b_half_height;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < NAX; k++) begin
        for (int j = 0; j < NAX; j++) begin
          px2[k][j] <= ax1[k] * ax1[j];
          py2[k][j] <= ay1[k] * ay1[j];
        end
        qx2[k] <= nx1 * ax1[k];
        qy2[k] <= ny1 * ay1[k];
      end
      hw2 <= hw1;
      hh2 <= hh1;
    end
  end

  for (genvar k = 0; k < NAX; k++) begin : g_axis
    for (genvar j = 0; j < NAX; j++) begin : g_dot
      assign sd[k][j] = obb_pkg::SW'(px2[k][j]) + obb_pkg::SW'(py2[k][j]);
      assign dmag_next[k][j] = sd[k][j][obb_pkg::SW-1] ? obb_pkg::MW'(-sd[k][j])
                                                       : obb_pkg::MW'(sd[k][j]);
    end
    assign sn[k] = obb_pkg::NSW'(qx2[k]) + obb_pkg::NSW'(qy2[k]);
    assign pmag_next[k] = sn[k][obb_pkg::NSW-1] ? obb_pkg::NMW'(-sn[k])
                                                : obb_pkg::NMW'(sn[k]);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      proj.dmag <= dmag_next;
      proj.pmag <= pmag_next;
      proj.hw   <= hw2;
      proj.hh   <= hh2;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/obb_rad.sv
`default_nettype none
// Stages 4..6: radius terms, per-box radii, separation decision.
module obb_rad (
  input  wire logic               clk,
  input  wire logic [2:0]         en,
  input  wire obb_pkg::obb_proj_t proj,
  output logic                    overlap_q
);

  localparam int NAX = obb_pkg::NAX;
  localparam int RW  = obb_pkg::RW;

  logic [obb_pkg::EW-1:0]   ext [NAX];
  logic [obb_pkg::TRW-1:0]  t4  [NAX][NAX];
  logic [obb_pkg::NMW-1:0]  pm4 [NAX];
  logic [obb_pkg::RBW-1:0]  rb5 [NAX][obb_pkg::NBX];
  logic [obb_pkg::NMW-1:0]  pm5 [NAX];
  logic [NAX-1:0]           sep;

  // even columns pair with half width, odd with half height
  assign ext[0] = proj.hw[0];
  assign ext[1] = proj.hh[0];
  assign ext[2] = proj.hw[1];
  assign ext[3] = proj.hh[1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < NAX; k++) begin
        for (int j = 0; j < NAX; j++) begin
          t4[k][j] <= obb_pkg::TRW'(ext[j]) * obb_pkg::TRW'(proj.dmag[k][j]);
        end
        pm4[k] <= proj.pmag[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < NAX; k++) begin
        rb5[k][0] <= obb_pkg::RBW'(t4[k][0]) + obb_pkg::RBW'(t4[k][1]);
        rb5[k][1] <= obb_pkg::RBW'(t4[k][2]) + obb_pkg::RBW'(t4[k][3]);
        pm5[k]    <= pm4[k];
      end
    end
  end

  // touching counts as separated
  for (genvar k = 0; k < NAX; k++) begin : g_sep
    assign sep[k] = (RW'(rb5[k][0]) + RW'(rb5[k][1]))
                    <= RW'({pm5[k], {obb_pkg::FW{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      overlap_q <= ~|sep;
    end
  end

endmodule
`default_nettype wire
